/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define SSP_ASSERT_IMPL(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ssp assertion failed");

// Next-cycle implication.
`define SSP_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ssp assertion failed");

`endif

/* hdl/ssp_pkg.sv */
// ----------------------------------------------------------------------------
// ssp_pkg
// Types and constants shared by the spread-step PWM level core.
// ----------------------------------------------------------------------------
`default_nettype none

package ssp_pkg;

  localparam int unsigned MAX_STEPS  = 1024;
  localparam int unsigned CNT_W      = 11;           // step_count / effective N
  localparam int unsigned DUTY_W     = 14;
  localparam int unsigned STEP_W     = 10;
  localparam int unsigned HIGH_W     = CNT_W;        // H is 0..N

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = DUTY_W;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY       = 1'b1;

  // H = floor((N * duty + 5000) / 10000), done as >>4 then * ceil(2^30 / 625) >> 30
  localparam int unsigned DUTY_FULL   = 10000;
  localparam int unsigned DUTY_HALF   = DUTY_FULL / 2;
  localparam int unsigned X_W         = CNT_W + DUTY_W;
  localparam int unsigned RECIP_PRE   = 4;
  localparam int unsigned RECIP_DIV   = DUTY_FULL >> RECIP_PRE;
  localparam int unsigned RECIP_SHIFT = 30;
  localparam int unsigned RECIP_M     = ((1 << RECIP_SHIFT) + RECIP_DIV - 1) / RECIP_DIV;
  localparam int unsigned RECIP_W     = 21;
  localparam int unsigned XS_W        = X_W - RECIP_PRE;
  localparam int unsigned RPROD_W     = XS_W + RECIP_W;
  localparam int unsigned HRAW_W      = 12;

  // cycles from a register write until H is valid again
  localparam int unsigned SETTLE_CYC  = 2;
  localparam int unsigned SETTLE_W    = 2;

  // H * s and the remainder pipeline
  localparam int unsigned PROD_W      = 2 * STEP_W;
  localparam int unsigned QUO_W       = STEP_W;
  localparam int unsigned DIV_W       = PROD_W + 1;
  localparam int unsigned LVL_W       = CNT_W + 2;

  // must be a power of two (pointers wrap)
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = 2;
  localparam int unsigned QCNT_W      = 3;

  typedef enum logic [1:0] {
    CLS_LOW,
    CLS_HIGH,
    CLS_TEST
  } ssp_cls_e;

  typedef struct packed {
    ssp_cls_e          cls;
    logic [PROD_W-1:0] prod;
  } ssp_item_t;

  typedef struct packed {
    logic [CNT_W-1:0]  steps;
    logic [HIGH_W-1:0] high;
    logic              settled;
  } ssp_cfg_t;

endpackage

`default_nettype wire

/* hdl/ssp_cfg.sv */
// ----------------------------------------------------------------------------
// ssp_cfg
// Configuration registers, effective step count and derived high count.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ssp_cfg
  import ssp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output ssp_cfg_t                   cfg_o
);

  logic [CNT_W-1:0]    step_count_q;
  logic [DUTY_W-1:0]   duty_q;
  logic [SETTLE_W-1:0] settle_q;
  logic [X_W-1:0]      x_q, x_d;
  logic [HIGH_W-1:0]   high_q, high_d;
  logic [CNT_W-1:0]    n_eff;
  logic [RPROD_W-1:0]  recip_prod;
  logic [HRAW_W-1:0]   h_raw;

  always_comb begin
    n_eff = step_count_q;
    if (step_count_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (step_count_q > CNT_W'(MAX_STEPS)) begin
      n_eff = CNT_W'(MAX_STEPS);
    end
  end

  assign x_d        = X_W'(n_eff) * X_W'(duty_q) + X_W'(DUTY_HALF);
  assign recip_prod = RPROD_W'(x_q[X_W-1:RECIP_PRE]) * RPROD_W'(RECIP_M);
  assign h_raw      = recip_prod[RECIP_SHIFT +: HRAW_W];
  // duty above full scale saturates to N
  assign high_d     = (h_raw > HRAW_W'(n_eff)) ? n_eff : h_raw[HIGH_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_count_q <= CNT_W'(1);
      duty_q       <= '0;
      settle_q     <= SETTLE_W'(SETTLE_CYC);
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_STEP_COUNT: step_count_q <= cfg_wdata_i[CNT_W-1:0];
          REG_DUTY:       duty_q       <= cfg_wdata_i[DUTY_W-1:0];
          default: ;
        endcase
        settle_q <= SETTLE_W'(SETTLE_CYC);
      end else if (settle_q != '0) begin
        settle_q <= settle_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    high_q <= high_d;
  end

  assign cfg_o.steps   = n_eff;
  assign cfg_o.high    = high_q;
  assign cfg_o.settled = (settle_q == '0);

  `SSP_ASSERT_NEXT(a_cfg_resettle, cfg_we_i, !cfg_o.settled)
  `SSP_ASSERT_IMPL(a_cfg_high_le_n, cfg_o.settled, cfg_o.high <= cfg_o.steps)

endmodule

`default_nettype wire

/* hdl/ssp_front.sv */
// ----------------------------------------------------------------------------
// ssp_front
// Accepts step indexes, sorts them into low / high / test, forms H * s.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ssp_front
  import ssp_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire logic [STEP_W-1:0] step_index_i,
  input  wire ssp_cfg_t          cfg_i,
  output logic                   push_o,
  output ssp_item_t              push_item_o,
  input  wire logic              q_full_i
);

  logic              f_vld_q;
  ssp_cls_e          f_cls_q, f_cls_d;
  logic [PROD_W-1:0] f_prod_q, f_prod_d;
  logic [CNT_W-1:0]  s_ext;
  logic              accept;

  assign s_ext      = CNT_W'(step_index_i);
  assign push_o     = f_vld_q && !q_full_i;
  assign in_stall_o = !(cfg_i.settled && (!f_vld_q || !q_full_i));
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    f_prod_d = '0;
    if (s_ext >= cfg_i.steps || cfg_i.high == '0) begin
      f_cls_d = CLS_LOW;
    end else if (cfg_i.high >= cfg_i.steps) begin
      f_cls_d = CLS_HIGH;
    end else begin
      // here H < N <= MAX_STEPS, so H fits the step index width
      f_cls_d  = CLS_TEST;
      f_prod_d = PROD_W'(cfg_i.high[STEP_W-1:0]) * PROD_W'(step_index_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_vld_q <= 1'b0;
    end else if (accept) begin
      f_vld_q <= 1'b1;
    end else if (push_o) begin
      f_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      f_cls_q  <= f_cls_d;
      f_prod_q <= f_prod_d;
    end
  end

  assign push_item_o.cls  = f_cls_q;
  assign push_item_o.prod = f_prod_q;

  `SSP_ASSERT_NEXT(a_front_out_of_range, accept && (s_ext >= cfg_i.steps), f_cls_q == CLS_LOW)

endmodule

`default_nettype wire

/* hdl/ssp_queue.sv */
// ----------------------------------------------------------------------------
// ssp_queue
// Small FIFO between the classifier and the remainder pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ssp_queue
  import ssp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire ssp_item_t push_item_i,
  input  wire logic      pop_i,
  output ssp_item_t      pop_item_o,
  output logic           full_o,
  output logic           empty_o
);

  ssp_item_t          mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;

  assign full_o     = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  `SSP_ASSERT_IMPL(a_queue_no_underflow, pop_i, !empty_o)
  `SSP_ASSERT_IMPL(a_queue_no_overflow, push_i && !pop_i, !full_o)

endmodule

`default_nettype wire

/* hdl/ssp_back.sv */
// ----------------------------------------------------------------------------
// ssp_back
// Restoring remainder pipeline (H*s mod N) and the registered level output.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ssp_back
  import ssp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire ssp_cfg_t  cfg_i,
  output logic           pop_o,
  input  wire ssp_item_t pop_item_i,
  input  wire logic      empty_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output logic           pin_level_o
);

  logic [QUO_W:0]    vld_q;
  ssp_cls_e          cls_q [QUO_W+1];
  logic [PROD_W-1:0] rem_q [QUO_W+1];
  logic [PROD_W-1:0] rem_nx [QUO_W];
  logic              out_vld_q;
  logic              pin_q, pin_d;
  logic              adv;
  logic [LVL_W-1:0]  r2, h_ext, n2;

  // whole pipe moves together unless the output is held
  assign adv   = !out_vld_q || !out_stall_i;
  assign pop_o = adv && !empty_i;

  // one quotient bit per stage, MSB first; H*s < N * 2^QUO_W holds for test items
  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    logic [DIV_W-1:0] div_sh;
    assign div_sh    = DIV_W'(cfg_i.steps) << (QUO_W - 1 - j);
    assign rem_nx[j] = (DIV_W'(rem_q[j]) >= div_sh) ?
                       rem_q[j] - div_sh[PROD_W-1:0] : rem_q[j];
  end

  // with r = H*s mod N: high iff 2r <= H or 2r + H > 2N
  assign r2    = LVL_W'({rem_q[QUO_W][CNT_W-1:0], 1'b0});
  assign h_ext = LVL_W'(cfg_i.high);
  assign n2    = LVL_W'({cfg_i.steps, 1'b0});

  always_comb begin
    case (cls_q[QUO_W])
      CLS_LOW:  pin_d = 1'b0;
      CLS_HIGH: pin_d = 1'b1;
      CLS_TEST: pin_d = (r2 <= h_ext) || ((r2 + h_ext) > n2);
      default:  pin_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      vld_q     <= {vld_q[QUO_W-1:0], pop_o};
      out_vld_q <= vld_q[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cls_q[0] <= pop_item_i.cls;
      rem_q[0] <= pop_item_i.prod;
      for (int j = 0; j < QUO_W; j++) begin
        cls_q[j+1] <= cls_q[j];
        rem_q[j+1] <= rem_nx[j];
      end
      pin_q <= pin_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign pin_level_o = pin_q;

  `SSP_ASSERT_IMPL(a_back_rem_below_n, vld_q[QUO_W] && (cls_q[QUO_W] == CLS_TEST),
                   rem_q[QUO_W] < PROD_W'(cfg_i.steps))

endmodule

`default_nettype wire

/* hdl/spread_step_pwm_level_core.sv */
// ----------------------------------------------------------------------------
// spread_step_pwm_level_core
// Spread-step PWM level: decides per step index whether the pin is driven high,
// spreading H = round(N * duty) high steps evenly over a cycle of N steps.
//
// Config port: cfg_we_i writes cfg_wdata_i to register cfg_idx_i
// (0 = step count, 1 = duty in 0.01 %). Write only while no item is in flight.
// Each write holds in_stall_o high while the high count settles.
// Input: step_index_i taken when in_valid_i && !in_stall_o.
// Output: one pin_level_o per item, in order, taken when out_valid_o &&
// !out_stall_i. An accepted item passes the classifier, the queue, the 10-stage
// remainder pipeline and the output register on its way to out_valid_o.
// Throughput is one item per cycle while in_stall_o is low; the remainder
// pipeline takes a new item every cycle it is not held.
// While the receiver stalls, the output and the pipeline hold; the 4-entry
// queue keeps taking items until it fills, then in_stall_o rises.
// Reset: registers return to step count 1, duty 0; pipeline and queue empty;
// input stalled after reset release until the high count settles.
// ----------------------------------------------------------------------------
`default_nettype none

module spread_step_pwm_level_core
  import ssp_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [STEP_W-1:0]     step_index_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic                       pin_level_o
);

  ssp_cfg_t  cfg;
  ssp_item_t push_item, pop_item;
  logic      push, pop, q_full, q_empty;

  ssp_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  ssp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .step_index_i (step_index_i),
    .cfg_i        (cfg),
    .push_o       (push),
    .push_item_o  (push_item),
    .q_full_i     (q_full)
  );

  ssp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .pop_i       (pop),
    .pop_item_o  (pop_item),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  ssp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .pop_o       (pop),
    .pop_item_i  (pop_item),
    .empty_i     (q_empty),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .pin_level_o (pin_level_o)
  );

endmodule

`default_nettype wire
